[hdl/timestamped_slot_queue_macros.svh]
// Assertion macros used by the checker file of the slot queue.
`ifndef TIMESTAMPED_SLOT_QUEUE_MACROS_SVH
`define TIMESTAMPED_SLOT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TSQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot queue check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define TSQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot queue check failed");

`endif

[hdl/tsq_pkg.sv]
// Shared constants, types and helpers of the timestamped slot queue.
package tsq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 32;

    localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = STAMP_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [STAMP_W-1:0] t_stamp;

    typedef struct packed {
        t_idx   rd_addr;
        logic   slot_we;
        t_idx   slot_addr;
        t_data  slot_data;
        t_stamp slot_stamp;
        logic   link_we;
        t_idx   link_addr;
        t_idx   link_val;
    } t_mem_req;

    typedef struct packed {
        t_data  data;
        t_stamp stamp;
        t_idx   link;
    } t_mem_rsp;

    // Link value of a slot that was never rewritten: the following slot, wrapping.
    function automatic t_idx next_slot(input t_idx idx);
        t_idx res;
        if (idx == t_idx'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

endpackage

[hdl/tsq_slot_store.sv]
// Slot storage: data word, time stamp and link of every slot, one read port.
module tsq_slot_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsq_pkg::t_mem_req i_req,
    output tsq_pkg::t_mem_rsp o_rsp
);
    import tsq_pkg::*;

    t_data  mem_data  [DEPTH];
    t_stamp mem_stamp [DEPTH];
    t_idx   mem_link  [DEPTH];

    logic [DEPTH-1:0] r_link_valid;
    t_data  r_rd_data;
    t_stamp r_rd_stamp;
    t_idx   r_rd_link;
    t_idx   r_rd_addr;
    logic   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.slot_we) begin
            mem_data[i_req.slot_addr]  <= i_req.slot_data;
            mem_stamp[i_req.slot_addr] <= i_req.slot_stamp;
        end
        if (i_req.link_we) begin
            mem_link[i_req.link_addr] <= i_req.link_val;
        end
        r_rd_data  <= mem_data[i_req.rd_addr];
        r_rd_stamp <= mem_stamp[i_req.rd_addr];
        r_rd_link  <= mem_link[i_req.rd_addr];
        r_rd_addr  <= i_req.rd_addr;
    end

    // A link never written since reset reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (i_req.link_we) begin
                r_link_valid[i_req.link_addr] <= 1'b1;
            end
            r_rd_valid <= r_link_valid[i_req.rd_addr];
        end
    end

    assign o_rsp.data  = r_rd_data;
    assign o_rsp.stamp = r_rd_stamp;
    assign o_rsp.link  = r_rd_valid ? r_rd_link : next_slot(r_rd_addr);

endmodule

[hdl/timestamped_slot_queue.sv]
// Usage:
//   A pool of 16 slots on a free list and a used list, with a wrapping
//   32-bit tick counter. Input transfers carry the opcode in i_s_tuser
//   (add, remove matching word, tick) and the word in i_s_tdata. Every
//   input transfer yields exactly one output transfer: status in
//   o_m_tuser, elapsed ticks and occupancy in o_m_tdata.
//   One item is in work at a time; o_s_tready is low from acceptance until
//   the result has been loaded into the output register.
//   Steps per item: tick, an unused opcode or a full or empty outcome
//   goes straight to loading the result; add stores the word and stamp
//   and takes the free head's link, then links the slot to the used tail
//   unless that list was empty; remove searches the used list from its
//   head, and on a match unlinks the slot and appends it to the free list.
//   The result is loaded at the edge where o_s_tready returns.
//   The search walks the used list one slot per cycle through the single
//   read port of the slot store; unlinking takes up to three link writes.
//   Reset empties the used list, puts all slots on the free list, clears
//   the tick counter and o_m_tvalid; no clearing pass is needed. If the
//   receiver stalls, the result holds in the output register; the next
//   item can be accepted and worked meanwhile, and its result waits until
//   the register is free.
module timestamped_slot_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [tsq_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // [31:0] item_data
    input  logic [1:0]                       i_s_tuser,  // [1:0] opcode
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [tsq_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // elapsed_ticks, occupancy, zero pad
    output logic [1:0]                       o_m_tuser   // [1:0] status
);
    import tsq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD1 = 3'd1;
    localparam logic [2:0] S_ADD2 = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_UNL1 = 3'd4;
    localparam logic [2:0] S_UNL2 = 3'd5;
    localparam logic [2:0] S_UNL3 = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state, n_state;
    t_stamp r_time, n_time;
    t_idx   r_used_first, n_used_first;
    t_idx   r_used_last, n_used_last;
    t_idx   r_free_first, n_free_first;
    t_idx   r_free_last, n_free_last;
    t_cnt   r_count, n_count;
    logic   r_out_valid, n_out_valid;

    t_idx   r_cur, n_cur;
    t_idx   r_prev, n_prev;
    t_idx   r_next, n_next;
    t_idx   r_k, n_k;
    t_data  r_key, n_key;
    logic [1:0] r_status, n_status;
    t_stamp r_elapsed, n_elapsed;
    logic [1:0] r_out_status, n_out_status;
    t_stamp r_out_elapsed, n_out_elapsed;
    t_cnt   r_out_occ, n_out_occ;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    logic     in_xfer;
    logic     last_pos;

    tsq_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign last_pos   = ({{(CNT_W-IDX_W){1'b0}}, r_k} == (r_count - t_cnt'(1)));

    always_comb begin
        n_state       = r_state;
        n_time        = r_time;
        n_used_first  = r_used_first;
        n_used_last   = r_used_last;
        n_free_first  = r_free_first;
        n_free_last   = r_free_last;
        n_count       = r_count;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_next        = r_next;
        n_k           = r_k;
        n_key         = r_key;
        n_status      = r_status;
        n_elapsed     = r_elapsed;
        n_out_status  = r_out_status;
        n_out_elapsed = r_out_elapsed;
        n_out_occ     = r_out_occ;

        mem_req            = '0;
        mem_req.rd_addr    = r_cur;
        mem_req.slot_addr  = r_cur;
        mem_req.slot_data  = i_s_tdata[DATA_W-1:0];
        mem_req.slot_stamp = r_time;
        mem_req.link_addr  = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_key     = i_s_tdata[DATA_W-1:0];
                    n_status  = ST_OK;
                    n_elapsed = '0;
                    n_state   = S_DONE;
                    unique case (i_s_tuser)
                        OP_ADD: begin
                            if (r_count == t_cnt'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                // Fetch the free head's link, store the word and stamp.
                                mem_req.rd_addr   = r_free_first;
                                mem_req.slot_we   = 1'b1;
                                mem_req.slot_addr = r_free_first;
                                n_cur             = r_free_first;
                                n_state           = S_ADD1;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_req.rd_addr = r_used_first;
                                n_cur           = r_used_first;
                                n_k             = '0;
                                n_state         = S_SRCH;
                            end
                        end
                        OP_TICK: begin
                            n_time = r_time + t_stamp'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD1: begin
                if ((r_count + t_cnt'(1)) < t_cnt'(DEPTH)) begin
                    n_free_first = mem_rsp.link;
                end
                mem_req.link_we  = 1'b1;
                mem_req.link_val = '0;
                if (r_count == '0) begin
                    n_used_first = r_cur;
                    n_used_last  = r_cur;
                    n_count      = r_count + t_cnt'(1);
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ADD2;
                end
            end
            S_ADD2: begin
                // Append to the used tail.
                mem_req.link_we   = 1'b1;
                mem_req.link_addr = r_used_last;
                mem_req.link_val  = r_cur;
                n_used_last       = r_cur;
                n_count           = r_count + t_cnt'(1);
                n_state           = S_DONE;
            end
            S_SRCH: begin
                if (mem_rsp.data == r_key) begin
                    n_elapsed = r_time - mem_rsp.stamp;
                    n_next    = mem_rsp.link;
                    n_state   = S_UNL1;
                end else if (last_pos) begin
                    n_status = ST_MISSING;
                    n_state  = S_DONE;
                end else begin
                    // Follow the link: the next slot is read in this cycle.
                    mem_req.rd_addr = mem_rsp.link;
                    n_prev          = r_cur;
                    n_cur           = mem_rsp.link;
                    n_k             = r_k + t_idx'(1);
                end
            end
            S_UNL1: begin
                if (r_k == '0) begin
                    n_used_first = r_next;
                end else begin
                    mem_req.link_we   = 1'b1;
                    mem_req.link_addr = r_prev;
                    mem_req.link_val  = r_next;
                    if (last_pos) begin
                        n_used_last = r_prev;
                    end
                end
                n_state = S_UNL2;
            end
            S_UNL2: begin
                mem_req.link_we  = 1'b1;
                mem_req.link_val = '0;
                if (r_count == t_cnt'(DEPTH)) begin
                    // Free list was empty: the freed slot is head and tail.
                    n_free_first = r_cur;
                    n_free_last  = r_cur;
                    n_count      = r_count - t_cnt'(1);
                    n_state      = S_DONE;
                end else begin
                    n_state = S_UNL3;
                end
            end
            S_UNL3: begin
                mem_req.link_we   = 1'b1;
                mem_req.link_addr = r_free_last;
                mem_req.link_val  = r_cur;
                n_free_last       = r_cur;
                n_count           = r_count - t_cnt'(1);
                n_state           = S_DONE;
            end
            S_DONE: begin
                // Load the result once the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_elapsed = r_elapsed;
                    n_out_occ     = r_count;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_time       <= '0;
            r_used_first <= '0;
            r_used_last  <= '0;
            r_free_first <= '0;
            r_free_last  <= t_idx'(DEPTH - 1);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_used_first <= n_used_first;
            r_used_last  <= n_used_last;
            r_free_first <= n_free_first;
            r_free_last  <= n_free_last;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_prev        <= n_prev;
        r_next        <= n_next;
        r_k           <= n_k;
        r_key         <= n_key;
        r_status      <= n_status;
        r_elapsed     <= n_elapsed;
        r_out_status  <= n_out_status;
        r_out_elapsed <= n_out_elapsed;
        r_out_occ     <= n_out_occ;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, r_out_occ, r_out_elapsed};

endmodule

[hdl/tsq_checker.sv]
// Port-level checks of the slot queue and their bind to the top level.
`include "timestamped_slot_queue_macros.svh"

module tsq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [tsq_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [1:0]                       o_m_tuser
);
    import tsq_pkg::*;

    logic [CNT_W-1:0]   occ;
    logic [STAMP_W-1:0] elapsed;

    assign occ     = o_m_tdata[STAMP_W +: CNT_W];
    assign elapsed = o_m_tdata[STAMP_W-1:0];

    `TSQ_ASSERT_NOW(a_full_occ, o_m_tvalid && (o_m_tuser == ST_FULL), occ == CNT_W'(DEPTH))
    `TSQ_ASSERT_NOW(a_empty_occ, o_m_tvalid && (o_m_tuser == ST_EMPTY), occ == '0)
    `TSQ_ASSERT_NOW(a_fail_no_time, o_m_tvalid && (o_m_tuser != ST_OK), elapsed == '0)
    `TSQ_ASSERT_NEXT(a_busy_after_xfer, i_s_tvalid && o_s_tready, !o_s_tready)
    `TSQ_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

endmodule

bind timestamped_slot_queue tsq_checker u_tsq_checker (.*);
